### sv/tmpr_pkg.sv
// Shared types, constants and a helper function of the tile map pixel renderer.
package tmpr_pkg;

  // Item kinds carried on the request channel.
  typedef enum logic [1:0] {
    KIND_TILE_MAP   = 2'd0,
    KIND_STAMP_WORD = 2'd1,
    KIND_PIXEL_BYTE = 2'd2,
    KIND_RENDER     = 2'd3
  } kind_t;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 9;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SCROLL_X = 1'b0,
    CFG_SCROLL_Y = 1'b1
  } cfg_reg_t;

  // Geometry of tiles and stamps.
  localparam int STAMP_SLOTS = 32;
  localparam int STAMP_BYTES = 32;

  localparam logic [15:0] STAMP_MASK  = 16'h07FF;
  localparam logic [7:0]  NIBBLE_MASK = 8'h0F;

  // Remainder by restoring subtraction over five steps. Valid while the value
  // is below 32 times the divisor, which holds for every use in the renderer.
  function automatic logic [15:0] mod_small(input logic [15:0] value,
                                            input logic [15:0] divisor);
    logic [20:0] rem;
    logic [20:0] dshift;
    rem = {5'b0, value};
    for (int k = 4; k >= 0; k--) begin
      dshift = {5'b0, divisor} << k;
      if (rem >= dshift) begin
        rem = rem - dshift;
      end
    end
    return rem[15:0];
  endfunction

endpackage

### sv/tmpr_if.sv
// Request and result channel interfaces of the tile map pixel renderer.
interface tmpr_in_if;
  import tmpr_pkg::*;
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [15:0] load_address;
  logic [15:0] load_data;
  logic [7:0]  view_x;
  logic [6:0]  view_y;

  modport source(output valid, kind, load_address, load_data, view_x, view_y,
                 input ready);
  modport sink(input valid, kind, load_address, load_data, view_x, view_y,
               output ready);
endinterface

interface tmpr_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] color_index;
  logic [7:0] out_x;
  logic [6:0] out_y;

  modport source(output valid, color_index, out_x, out_y, input ready);
  modport sink(input valid, color_index, out_x, out_y, output ready);
endinterface

### sv/tmpr_ram.sv
// Generic single-port synchronous RAM with registered read data.
module tmpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data holds while the port is not enabled.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

### sv/tile_map_pixel_renderer.sv
// Top level of the tile map pixel renderer: a three-lookup memory pipeline.
//
// Loads and renders share one request channel and one pipeline. An item is
// accepted every cycle while the result register is free or being drained, so
// the block sustains one item per clock. A render item runs through three
// dependent memory reads (tile map, stamp word, pixel byte), one per stage, and
// its result is registered through stages 1 to 3 into the output register.
// Each load writes its store in the same stage that renders read it, so all
// items take effect in arrival order without forwarding. A stalled result
// freezes the whole pipeline, including the memory read registers. Scroll
// registers must only be written while the pipeline is empty. Stores are not
// cleared by reset; a render that reads an entry never loaded returns an
// unspecified color.
module tile_map_pixel_renderer #(
  parameter int MAP_TILES_W = 64,
  parameter int MAP_TILES_H = 64,
  parameter int TILE_COUNT  = 256,
  parameter int STAMP_COUNT = 2048
) (
  input  logic                             clk,
  input  logic                             rst,
  tmpr_in_if.sink                          req,
  tmpr_out_if.source                       rsp,
  input  logic                             cfg_we,
  input  logic [tmpr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tmpr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tmpr_pkg::*;

  localparam int TM_DEPTH = MAP_TILES_W * MAP_TILES_H;
  localparam int SW_DEPTH = TILE_COUNT * STAMP_SLOTS;
  localparam int PX_DEPTH = STAMP_COUNT * STAMP_BYTES;
  localparam int TM_AW    = $clog2(TM_DEPTH);
  localparam int SW_AW    = $clog2(SW_DEPTH);
  localparam int PX_AW    = $clog2(PX_DEPTH);

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [15:0] load_address;
    logic [15:0] load_data;
    logic [7:0]  view_x;
    logic [6:0]  view_y;
    logic [1:0]  srow;
    logic [2:0]  scol;
  } stage_t;

  logic [8:0] scroll_x;
  logic [7:0] scroll_y;

  stage_t s1, s2, s3;
  logic   advance;

  logic       out_valid;
  logic [3:0] color_index;
  logic [7:0] out_x;
  logic [6:0] out_y;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_x <= '0;
      scroll_y <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SCROLL_X: scroll_x <= cfg_data;
        CFG_SCROLL_Y: scroll_y <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves when the result register can take a new value.
  assign advance   = !out_valid || rsp.ready;
  assign req.ready = advance;

  // Stage 0: stamp position in the map and tile map address.
  logic [9:0]        col;
  logic [8:0]        row;
  logic [15:0]       tcol;
  logic [15:0]       trow;
  logic [16:0]       tm_index;
  logic [TM_AW-1:0]  tm_addr;
  logic              tm_we;
  logic [7:0]        tm_rdata;
  stage_t            s0;

  always_comb begin
    col      = {1'b0, scroll_x} + {5'b0, req.view_x[7:3]};
    row      = {1'b0, scroll_y} + {5'b0, req.view_y[6:3]};
    tcol     = mod_small({9'b0, col[9:3]}, 16'(MAP_TILES_W));
    trow     = mod_small({9'b0, row[8:2]}, 16'(MAP_TILES_H));
    tm_index = {1'b0, trow} * 17'(MAP_TILES_W) + {1'b0, tcol};
    tm_we    = req.valid && (req.kind == KIND_TILE_MAP) &&
               ({1'b0, req.load_address} < 17'(TM_DEPTH));
    tm_addr  = tm_we ? TM_AW'(req.load_address) : TM_AW'(tm_index);

    s0.valid        = req.valid;
    s0.kind         = req.kind;
    s0.load_address = req.load_address;
    s0.load_data    = req.load_data;
    s0.view_x       = req.view_x;
    s0.view_y       = req.view_y;
    s0.srow         = row[1:0];
    s0.scol         = col[2:0];
  end

  tmpr_ram #(.WIDTH(8), .DEPTH(TM_DEPTH)) u_tile_map (
    .clk   (clk),
    .en    (advance),
    .we    (tm_we),
    .addr  (tm_addr),
    .wdata (req.load_data[7:0]),
    .rdata (tm_rdata)
  );

  // Stage 1: tile number and stamp word address.
  logic [15:0]      tile;
  logic [SW_AW-1:0] sw_addr;
  logic             sw_we;
  logic [15:0]      sw_rdata;

  always_comb begin
    tile    = mod_small({8'b0, tm_rdata}, 16'(TILE_COUNT));
    sw_we   = s1.valid && (s1.kind == KIND_STAMP_WORD) &&
              ({2'b0, s1.load_address} < 18'(SW_DEPTH));
    sw_addr = sw_we ? SW_AW'(s1.load_address) : SW_AW'({tile[11:0], s1.srow, s1.scol});
  end

  tmpr_ram #(.WIDTH(16), .DEPTH(SW_DEPTH)) u_stamp_word (
    .clk   (clk),
    .en    (advance),
    .we    (sw_we),
    .addr  (sw_addr),
    .wdata (s1.load_data),
    .rdata (sw_rdata)
  );

  // Stage 2: stamp number and pixel byte address.
  logic [15:0]      stamp;
  logic [PX_AW-1:0] px_addr;
  logic             px_we;
  logic [7:0]       px_rdata;

  always_comb begin
    stamp   = mod_small(sw_rdata & STAMP_MASK, 16'(STAMP_COUNT));
    px_we   = s2.valid && (s2.kind == KIND_PIXEL_BYTE) &&
              ({1'b0, s2.load_address} < 17'(PX_DEPTH));
    px_addr = px_we ? PX_AW'(s2.load_address) :
                      PX_AW'({stamp[10:0], s2.view_y[2:0], s2.view_x[2:1]});
  end

  tmpr_ram #(.WIDTH(8), .DEPTH(PX_DEPTH)) u_stamp_pixel (
    .clk   (clk),
    .en    (advance),
    .we    (px_we),
    .addr  (px_addr),
    .wdata (s2.load_data[7:0]),
    .rdata (px_rdata)
  );

  // Stage 3: nibble select; the left pixel of a byte is the high nibble.
  logic [7:0] nibble;
  assign nibble = (s3.view_x[0] ? px_rdata : (px_rdata >> 4)) & NIBBLE_MASK;

  // Pipeline stage registers; only the valid bits are reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
    end else if (advance) begin
      s1.valid <= s0.valid;
      s2.valid <= s1.valid;
      s3.valid <= s2.valid;
    end
    if (advance) begin
      s1.kind         <= s0.kind;
      s1.load_address <= s0.load_address;
      s1.load_data    <= s0.load_data;
      s1.view_x       <= s0.view_x;
      s1.view_y       <= s0.view_y;
      s1.srow         <= s0.srow;
      s1.scol         <= s0.scol;
      s2.kind         <= s1.kind;
      s2.load_address <= s1.load_address;
      s2.load_data    <= s1.load_data;
      s2.view_x       <= s1.view_x;
      s2.view_y       <= s1.view_y;
      s2.srow         <= s1.srow;
      s2.scol         <= s1.scol;
      s3.kind         <= s2.kind;
      s3.load_address <= s2.load_address;
      s3.load_data    <= s2.load_data;
      s3.view_x       <= s2.view_x;
      s3.view_y       <= s2.view_y;
      s3.srow         <= s2.srow;
      s3.scol         <= s2.scol;
    end
  end

  // Result register: only render items produce a result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s3.valid && (s3.kind == KIND_RENDER);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      color_index <= nibble[3:0];
      out_x       <= s3.view_x;
      out_y       <= s3.view_y;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.color_index = color_index;
  assign rsp.out_x       = out_x;
  assign rsp.out_y       = out_y;

endmodule

### verif/tile_map_pixel_renderer_tb.sv
// Testbench for the tile map pixel renderer: directed and random items checked against a predictor.
module tile_map_pixel_renderer_tb;
  import tmpr_pkg::*;

  // Geometry of the block under test at its default parameters.
  localparam int MAP_TILES_W      = 64;
  localparam int MAP_TILES_H      = 64;
  localparam int TILE_COUNT       = 256;
  localparam int STAMP_COUNT      = 2048;
  localparam int TILE_MAP_DEPTH   = MAP_TILES_W * MAP_TILES_H;
  localparam int STAMP_WORD_DEPTH = TILE_COUNT * STAMP_SLOTS;
  localparam int PIXEL_DEPTH      = STAMP_COUNT * STAMP_BYTES;
  localparam int MAX_SCROLL_X     = 480;
  localparam int MAX_SCROLL_Y     = 240;
  localparam int DRAIN_CYCLES     = 10;
  localparam int RANDOM_ITEMS     = 1800;

  typedef struct packed {
    logic [3:0] color;
    logic [7:0] x;
    logic [6:0] y;
  } pixel_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  tmpr_in_if  req_if ();
  tmpr_out_if rsp_if ();

  tile_map_pixel_renderer u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if.sink),
    .rsp       (rsp_if.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the block: scroll registers and the three stores.
  int          scroll_x_cfg;
  int          scroll_y_cfg;
  logic [7:0]  tile_map_img     [TILE_MAP_DEPTH];
  bit          tile_map_valid   [TILE_MAP_DEPTH];
  logic [15:0] stamp_word_img   [STAMP_WORD_DEPTH];
  bit          stamp_word_valid [STAMP_WORD_DEPTH];
  logic [7:0]  pixel_byte_img   [PIXEL_DEPTH];
  bit          pixel_byte_valid [PIXEL_DEPTH];

  pixel_t pending_pixels[$];
  int     error_count;
  int     accepted_count;
  bit     source_idle_on;
  bit     sink_idle_on;
  int     stall_left;

  always #1 clk = ~clk;

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Tile map entry seen by a viewport pixel under the current scroll.
  function automatic int map_index(logic [7:0] vx, logic [6:0] vy);
    int col;
    int row;
    col = scroll_x_cfg + vx / 8;
    row = scroll_y_cfg + vy / 8;
    return ((row / 4) % MAP_TILES_H) * MAP_TILES_W + (col / 8) % MAP_TILES_W;
  endfunction

  // Stamp word entry of a tile for a viewport pixel.
  function automatic int word_index(int tile, logic [7:0] vx, logic [6:0] vy);
    int col;
    int row;
    col = scroll_x_cfg + vx / 8;
    row = scroll_y_cfg + vy / 8;
    return (tile % TILE_COUNT) * STAMP_SLOTS + (row % 4) * 8 + col % 8;
  endfunction

  // Pixel byte entry of a stamp for a viewport pixel.
  function automatic int byte_index(int stamp, logic [7:0] vx, logic [6:0] vy);
    return (stamp % STAMP_COUNT) * STAMP_BYTES + (vy % 8) * 4 + (vx % 8) / 2;
  endfunction

  // Tile numbers: half from a small pool so tiles get reused, high byte random.
  function automatic logic [15:0] fill_tile();
    logic [15:0] d;
    d = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 1) == 0) d[7:0] = 8'($urandom_range(0, 7));
    return d;
  endfunction

  // Stamp words: half from a small stamp pool, bits above the mask random.
  function automatic logic [15:0] fill_word();
    logic [15:0] d;
    d = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 1) == 0) d[10:0] = 11'($urandom_range(0, 15));
    return d;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Send one item and update the shadow state once it is accepted.
  task automatic send_item(kind_t kind, logic [15:0] addr, logic [15:0] data,
                           logic [7:0] vx, logic [6:0] vy);
    int     gap;
    int     m;
    int     w;
    int     b;
    logic [7:0] byte_val;
    pixel_t want;
    gap = pick_gap(source_idle_on);
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.kind         = kind;
    req_if.load_address = addr;
    req_if.load_data    = data;
    req_if.view_x       = vx;
    req_if.view_y       = vy;
    req_if.valid        = 1'b1;
    do @(posedge clk); while (req_if.ready !== 1'b1);

    case (kind)
      KIND_TILE_MAP: begin
        if (addr < TILE_MAP_DEPTH) begin
          tile_map_img[addr]   = data[7:0];
          tile_map_valid[addr] = 1'b1;
          accepted_count++;
        end
      end
      KIND_STAMP_WORD: begin
        if (addr < STAMP_WORD_DEPTH) begin
          stamp_word_img[addr]   = data;
          stamp_word_valid[addr] = 1'b1;
          accepted_count++;
        end
      end
      KIND_PIXEL_BYTE: begin
        pixel_byte_img[addr]   = data[7:0];
        pixel_byte_valid[addr] = 1'b1;
        accepted_count++;
      end
      default: begin
        // Three dependent lookups, then the nibble picked by the x parity.
        m = map_index(vx, vy);
        w = word_index(tile_map_img[m], vx, vy);
        b = byte_index(stamp_word_img[w] & STAMP_MASK, vx, vy);
        byte_val = pixel_byte_img[b];
        want.color = vx[0] ? 4'(byte_val & NIBBLE_MASK) : 4'((byte_val >> 4) & NIBBLE_MASK);
        want.x = vx;
        want.y = vy;
        pending_pixels.push_back(want);
        accepted_count++;
      end
    endcase
  endtask

  // Render one pixel, first loading any store entry on its path not yet written.
  task automatic render_pixel_at(logic [7:0] vx, logic [6:0] vy);
    int m;
    int w;
    int b;
    m = map_index(vx, vy);
    if (!tile_map_valid[m])
      send_item(KIND_TILE_MAP, 16'(m), fill_tile(), 8'($urandom), 7'($urandom));
    w = word_index(tile_map_img[m], vx, vy);
    if (!stamp_word_valid[w])
      send_item(KIND_STAMP_WORD, 16'(w), fill_word(), 8'($urandom), 7'($urandom));
    b = byte_index(stamp_word_img[w] & STAMP_MASK, vx, vy);
    if (!pixel_byte_valid[b])
      send_item(KIND_PIXEL_BYTE, 16'(b), 16'($urandom), 8'($urandom), 7'($urandom));
    send_item(KIND_RENDER, 16'($urandom), 16'($urandom), vx, vy);
  endtask

  // Write both scroll registers once the pipeline has emptied.
  task automatic set_scroll(int sx, int sy);
    @(negedge clk);
    req_if.valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = CFG_SCROLL_X;
    cfg_data  = CFG_DATA_W'(sx);
    @(negedge clk);
    cfg_index = CFG_SCROLL_Y;
    cfg_data  = CFG_DATA_W'(sy);
    @(negedge clk);
    cfg_we = 1'b0;
    scroll_x_cfg = sx;
    scroll_y_cfg = sy;
  endtask

  // Extreme tile and stamp numbers, both nibbles, loads past the tile map and stamp word ends.
  task automatic test_corner_items();
    set_scroll(0, 0);
    send_item(KIND_TILE_MAP, 16'd0, 16'hFFFF, 8'd0, 7'd0);
    send_item(KIND_STAMP_WORD, 16'(255 * STAMP_SLOTS), 16'hFFFF, 8'hFF, 7'h7F);
    send_item(KIND_PIXEL_BYTE, 16'(PIXEL_DEPTH - STAMP_BYTES), 16'h12A5, 8'd0, 7'd0);
    render_pixel_at(8'd0, 7'd0);
    render_pixel_at(8'd1, 7'd0);
    send_item(KIND_TILE_MAP, 16'(TILE_MAP_DEPTH), 16'h0000, 8'd0, 7'd0);
    send_item(KIND_TILE_MAP, 16'hFFFF, 16'h0000, 8'hFF, 7'h7F);
    send_item(KIND_STAMP_WORD, 16'(STAMP_WORD_DEPTH), 16'h0000, 8'd0, 7'd0);
    send_item(KIND_STAMP_WORD, 16'hFFFF, 16'h0000, 8'hFF, 7'h7F);
    render_pixel_at(8'd0, 7'd0);
    // Bottom right pixel reaches the last stamp word and the last pixel byte.
    send_item(KIND_TILE_MAP, 16'd195, 16'h00FF, 8'd0, 7'd0);
    send_item(KIND_STAMP_WORD, 16'(STAMP_WORD_DEPTH - 1), 16'hA7FF, 8'd0, 7'd0);
    send_item(KIND_PIXEL_BYTE, 16'hFFFF, 16'h003C, 8'd0, 7'd0);
    render_pixel_at(8'd255, 7'd127);
    render_pixel_at(8'd254, 7'd127);
    // Tile zero and stamp zero.
    send_item(KIND_TILE_MAP, 16'd1, 16'h0000, 8'd0, 7'd0);
    send_item(KIND_STAMP_WORD, 16'd0, 16'h0000, 8'd0, 7'd0);
    send_item(KIND_PIXEL_BYTE, 16'd0, 16'h00F0, 8'd0, 7'd0);
    render_pixel_at(8'd64, 7'd0);
    render_pixel_at(8'd65, 7'd0);
  endtask

  // Corners of the view with the scroll values at MAX_SCROLL_X, MAX_SCROLL_Y or zero.
  task automatic test_scroll_corners();
    set_scroll(MAX_SCROLL_X, MAX_SCROLL_Y);
    render_pixel_at(8'd255, 7'd127);
    render_pixel_at(8'd0, 7'd0);
    set_scroll(MAX_SCROLL_X, 0);
    render_pixel_at(8'd255, 7'd0);
    set_scroll(0, MAX_SCROLL_Y);
    render_pixel_at(8'd0, 7'd127);
  endtask

  // Phases of random traffic, each under its own scroll and idling setting.
  task automatic test_random_traffic(int count);
    int         target;
    int         phase_end;
    int         phase;
    int         act;
    int         run_len;
    logic [7:0] vx;
    logic [6:0] vy;
    target = accepted_count + count;
    phase  = 0;
    while (accepted_count < target) begin
      case (phase)
        0: set_scroll(0, 0);
        1: set_scroll(MAX_SCROLL_X, MAX_SCROLL_Y);
        2: set_scroll($urandom_range(0, MAX_SCROLL_X), $urandom_range(0, MAX_SCROLL_Y));
        3: set_scroll(0, MAX_SCROLL_Y);
        4: set_scroll(MAX_SCROLL_X, 0);
        default: set_scroll($urandom_range(0, MAX_SCROLL_X), $urandom_range(0, MAX_SCROLL_Y));
      endcase
      source_idle_on = (phase == 2) ? 1'b0 : ($urandom_range(0, 9) < 7);
      sink_idle_on   = (phase == 2) ? 1'b0 : ($urandom_range(0, 9) < 7);
      phase_end = accepted_count + 200;
      while (accepted_count < phase_end && accepted_count < target) begin
        act = $urandom_range(0, 99);
        if (act < 35) begin
          // Raster run along one row, as a display fetch would issue it.
          run_len = $urandom_range(8, 32);
          vx = 8'($urandom);
          vy = 7'($urandom);
          repeat (run_len) begin
            render_pixel_at(vx, vy);
            vx++;
          end
        end else if (act < 60) begin
          render_pixel_at(8'($urandom), 7'($urandom));
        end else if (act < 75) begin
          send_item(KIND_TILE_MAP, 16'($urandom_range(0, TILE_MAP_DEPTH - 1)), fill_tile(),
                    8'($urandom), 7'($urandom));
        end else if (act < 85) begin
          send_item(KIND_STAMP_WORD, 16'($urandom_range(0, STAMP_WORD_DEPTH - 1)),
                    fill_word(), 8'($urandom), 7'($urandom));
        end else if (act < 95) begin
          send_item(KIND_PIXEL_BYTE, 16'($urandom), 16'($urandom), 8'($urandom),
                    7'($urandom));
        end else begin
          // Loads at any address, most of them past the end of their store.
          send_item(kind_t'($urandom_range(0, 2)), 16'($urandom), 16'($urandom),
                    8'($urandom), 7'($urandom));
        end
      end
      phase++;
    end
  endtask

  // Let the last results drain, then give the verdict.
  task automatic finish_run();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[tile_map_pixel_renderer] OK");
    end else begin
      $display("[tile_map_pixel_renderer] ERROR");
    end
    $finish;
  endtask

  // Receiver side: ready with random stalls.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      rsp_if.ready = 1'b0;
      stall_left--;
    end else begin
      rsp_if.ready = 1'b1;
      stall_left = pick_gap(sink_idle_on);
    end
  end

  // Compare each accepted result item with the oldest predicted pixel.
  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel at (%0d,%0d)",
                                  rsp_if.out_x, rsp_if.out_y));
      end else begin
        want = pending_pixels.pop_front();
        if (rsp_if.color_index !== want.color)
          report_mismatch($sformatf("color at (%0d,%0d): got %h, want %h",
                                    want.x, want.y, rsp_if.color_index, want.color));
        if (rsp_if.out_x !== want.x)
          report_mismatch($sformatf("out_x: got %0d, want %0d", rsp_if.out_x, want.x));
        if (rsp_if.out_y !== want.y)
          report_mismatch($sformatf("out_y: got %0d, want %0d", rsp_if.out_y, want.y));
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #8000000;
    $display("[tile_map_pixel_renderer] ERROR");
    $finish;
  end

  initial begin
    clk                 = 1'b0;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = CFG_SCROLL_X;
    cfg_data            = '0;
    req_if.valid        = 1'b0;
    req_if.kind         = KIND_TILE_MAP;
    req_if.load_address = '0;
    req_if.load_data    = '0;
    req_if.view_x       = '0;
    req_if.view_y       = '0;
    rsp_if.ready        = 1'b0;
    stall_left          = 0;
    error_count         = 0;
    accepted_count      = 0;
    scroll_x_cfg        = 0;
    scroll_y_cfg        = 0;
    source_idle_on      = 1'b1;
    sink_idle_on        = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_corner_items();
    test_scroll_corners();
    test_random_traffic(RANDOM_ITEMS);
    finish_run();
  end

endmodule

### filelist.f
sv/tmpr_pkg.sv
sv/tmpr_if.sv
sv/tmpr_ram.sv
sv/tile_map_pixel_renderer.sv
verif/tile_map_pixel_renderer_tb.sv
